FILE: rtl/battery_soc_rate_limited_tracker_defines.svh
// assertion macros used by the tracker controller
`ifndef BATTERY_SOC_RATE_LIMITED_TRACKER_DEFINES_SVH
`define BATTERY_SOC_RATE_LIMITED_TRACKER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define BSRT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define BSRT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bsrt_pkg.sv
// types, constants and the discharge curve of the soc tracker
package bsrt_pkg;

  localparam int MV_W         = 13;
  localparam int PCT_W        = 7;
  localparam int TIME_W       = 32;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 32;
  localparam int CURVE_POINTS = 21;
  localparam int SEG_W        = $clog2(CURVE_POINTS);
  localparam int PROD_W       = MV_W + PCT_W;
  localparam int NUM_W        = PROD_W + 1;
  localparam int DIV_STEPS    = PCT_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam int FILT_W       = MV_W + 3;

  localparam logic [SEG_W-1:0]     SEG_LAST  = SEG_W'(CURVE_POINTS - 1);
  localparam logic [DIV_CNT_W-1:0] DIV_FIRST = DIV_CNT_W'(DIV_STEPS - 1);
  localparam logic [PCT_W-1:0]     PCT_FULL  = PCT_W'(100);
  localparam logic [FILT_W-1:0]    FILT_ROUND = FILT_W'(4);

  localparam logic [TIME_W-1:0] RST_CHARGE_STEP    = TIME_W'(120000);
  localparam logic [TIME_W-1:0] RST_DISCHARGE_STEP = TIME_W'(300000);
  localparam logic [MV_W-1:0]   RST_LOW_CUTOFF     = MV_W'(3500);
  localparam logic [PCT_W-1:0]  RST_LOW_CLAMP      = PCT_W'(3);

  localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
    13'd3450, 13'd3610, 13'd3690, 13'd3710, 13'd3730,
    13'd3750, 13'd3770, 13'd3790, 13'd3800, 13'd3820,
    13'd3840, 13'd3850, 13'd3870, 13'd3910, 13'd3950,
    13'd3980, 13'd4020, 13'd4080, 13'd4110, 13'd4150,
    13'd4200
  };

  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
    7'd0,  7'd5,  7'd10, 7'd15, 7'd20,
    7'd25, 7'd30, 7'd35, 7'd40, 7'd45,
    7'd50, 7'd55, 7'd60, 7'd65, 7'd70,
    7'd75, 7'd80, 7'd85, 7'd90, 7'd95,
    7'd100
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHARGE_STEP    = 8'd0,
    CFG_DISCHARGE_STEP = 8'd1,
    CFG_LOW_CUTOFF     = 8'd2,
    CFG_LOW_CLAMP      = 8'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [MV_W-1:0]   sample_mv;
    logic              charging;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [PCT_W-1:0] percent;
    logic [MV_W-1:0]  smoothed_mv;
    logic             ready_res;
    logic             percent_changed;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_beat_t;

  typedef struct packed {
    logic [TIME_W-1:0] charge_step_ms;
    logic [TIME_W-1:0] discharge_step_ms;
    logic [MV_W-1:0]   low_cutoff_mv;
    logic [PCT_W-1:0]  low_clamp_percent;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILTER,
    S_SEARCH,
    S_MULT,
    S_ADD,
    S_DIV,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic load;
    logic filter;
    logic search;
    logic mult;
    logic add;
    logic div;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic seg_direct;
    logic seg_found;
    logic div_last;
  } status_t;

endpackage

FILE: rtl/bsrt_channels.sv
// valid/ready channel interfaces for input, result and configuration beats
interface bsrt_in_if;
  logic               valid;
  logic               ready;
  bsrt_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bsrt_out_if;
  logic                valid;
  logic                ready;
  bsrt_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bsrt_cfg_if;
  logic                valid;
  logic                ready;
  bsrt_pkg::cfg_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/bsrt_cfg_regs.sv
// configuration register file of the soc tracker
module bsrt_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  bsrt_pkg::cfg_beat_t wr_beat,
  output bsrt_pkg::cfg_t      cfg
);

  bsrt_pkg::cfg_t cfg_r;
  bsrt_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_beat.index)
        bsrt_pkg::CFG_CHARGE_STEP:    cfg_nxt.charge_step_ms    = wr_beat.value;
        bsrt_pkg::CFG_DISCHARGE_STEP: cfg_nxt.discharge_step_ms = wr_beat.value;
        bsrt_pkg::CFG_LOW_CUTOFF:
          cfg_nxt.low_cutoff_mv = wr_beat.value[bsrt_pkg::MV_W-1:0];
        bsrt_pkg::CFG_LOW_CLAMP:
          cfg_nxt.low_clamp_percent = wr_beat.value[bsrt_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.charge_step_ms    <= bsrt_pkg::RST_CHARGE_STEP;
      cfg_r.discharge_step_ms <= bsrt_pkg::RST_DISCHARGE_STEP;
      cfg_r.low_cutoff_mv     <= bsrt_pkg::RST_LOW_CUTOFF;
      cfg_r.low_clamp_percent <= bsrt_pkg::RST_LOW_CLAMP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/bsrt_dp.sv
// datapath: filter, curve segment search, rounding divider and percent update
module bsrt_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bsrt_pkg::cmd_t       cmd,
  output bsrt_pkg::status_t    st,
  input  bsrt_pkg::in_item_t   in_item,
  input  bsrt_pkg::cfg_t       cfg,
  output bsrt_pkg::out_item_t  out_item
);

  localparam int MV_W   = bsrt_pkg::MV_W;
  localparam int PCT_W  = bsrt_pkg::PCT_W;
  localparam int TIME_W = bsrt_pkg::TIME_W;
  localparam int SEG_W  = bsrt_pkg::SEG_W;
  localparam int PROD_W = bsrt_pkg::PROD_W;
  localparam int NUM_W  = bsrt_pkg::NUM_W;
  localparam int CNT_W  = bsrt_pkg::DIV_CNT_W;
  localparam int FILT_W = bsrt_pkg::FILT_W;

  // beat latched at accept
  logic [MV_W-1:0]   m_r;
  logic              chg_r;
  logic [TIME_W-1:0] now_r;

  // tracker state
  logic [MV_W-1:0]   avg_r;
  logic [PCT_W-1:0]  shown_r;
  logic              seeded_r;
  logic [TIME_W-1:0] last_r;

  // working registers
  logic [MV_W-1:0]   lv_r;
  logic [TIME_W-1:0] elapsed_r;
  logic [SEG_W-1:0]  k_r;
  logic [MV_W-1:0]   into_r;
  logic [MV_W-1:0]   span_r;
  logic [PCT_W-1:0]  rise_r;
  logic [PCT_W-1:0]  base_r;
  logic [PCT_W-1:0]  q_r;
  logic [PROD_W-1:0] prod_r;
  logic [NUM_W-1:0]  rem_r;
  logic [CNT_W-1:0]  cnt_r;
  bsrt_pkg::out_item_t out_r;

  logic [FILT_W-1:0] filt_sum;
  logic [MV_W-1:0]   lv_nxt;
  logic [SEG_W-1:0]  prev_k;
  logic [MV_W-1:0]   pt_mv;
  logic [MV_W-1:0]   prev_mv;
  logic [PCT_W-1:0]  pt_pct;
  logic [PCT_W-1:0]  prev_pct;
  logic              hit;
  logic              first;
  logic              last;
  logic [MV_W-1:0]   span;
  logic [NUM_W-1:0]  div_sh;
  logic [PCT_W-1:0]  target;
  logic [PCT_W-1:0]  shown_nxt;
  logic              touch;

  // 7*avg + m + 4, never above 16 bits for 13-bit operands
  assign filt_sum = {avg_r, 3'b000} - FILT_W'(avg_r) + FILT_W'(m_r) + bsrt_pkg::FILT_ROUND;
  assign lv_nxt   = (!seeded_r || avg_r == '0) ? m_r : filt_sum[FILT_W-1:3];

  // segment between point k-1 and point k
  assign first    = (k_r == '0);
  assign last     = (k_r == bsrt_pkg::SEG_LAST);
  assign prev_k   = first ? '0 : k_r - SEG_W'(1);
  assign pt_mv    = bsrt_pkg::CURVE_MV[k_r];
  assign pt_pct   = bsrt_pkg::CURVE_PCT[k_r];
  assign prev_mv  = bsrt_pkg::CURVE_MV[prev_k];
  assign prev_pct = bsrt_pkg::CURVE_PCT[prev_k];
  assign hit      = (lv_r <= pt_mv);
  assign span     = pt_mv - prev_mv;

  assign st.seg_direct = (hit && first) || (hit && span == '0) || (!hit && last);
  assign st.seg_found  = hit && !first && span != '0;
  assign st.div_last   = (cnt_r == '0);

  assign div_sh = NUM_W'(span_r) << cnt_r;
  assign target = base_r + q_r;

  always_comb begin
    shown_nxt = shown_r;
    touch     = 1'b0;
    if (!seeded_r) begin
      shown_nxt = target;
      touch     = 1'b1;
    end else if (lv_r <= cfg.low_cutoff_mv) begin
      if (shown_r > cfg.low_clamp_percent) shown_nxt = cfg.low_clamp_percent;
      touch = 1'b1;
    end else if (chg_r) begin
      if (target > shown_r && elapsed_r >= cfg.charge_step_ms) begin
        shown_nxt = shown_r + PCT_W'(1);
        touch     = 1'b1;
      end
    end else begin
      if (target < shown_r && elapsed_r >= cfg.discharge_step_ms) begin
        shown_nxt = shown_r - PCT_W'(1);
        touch     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r    <= '0;
      shown_r  <= '0;
      seeded_r <= 1'b0;
      last_r   <= '0;
    end else if (cmd.commit) begin
      avg_r    <= lv_r;
      shown_r  <= shown_nxt;
      seeded_r <= 1'b1;
      if (touch) last_r <= now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_r   <= in_item.sample_mv;
      chg_r <= in_item.charging;
      now_r <= in_item.now_ms;
    end
    if (cmd.filter) begin
      lv_r      <= lv_nxt;
      elapsed_r <= now_r - last_r;
      k_r       <= '0;
    end
    if (cmd.search) begin
      if (hit && first) begin
        base_r <= pt_pct;
        q_r    <= '0;
      end else if (hit && span == '0) begin
        base_r <= pt_pct;
        q_r    <= '0;
      end else if (hit) begin
        into_r <= lv_r - prev_mv;
        span_r <= span;
        rise_r <= pt_pct - prev_pct;
        base_r <= prev_pct;
      end else if (last) begin
        base_r <= bsrt_pkg::PCT_FULL;
        q_r    <= '0;
      end else begin
        k_r <= k_r + SEG_W'(1);
      end
    end
    if (cmd.mult) begin
      prod_r <= PROD_W'(into_r) * PROD_W'(rise_r);
      q_r    <= '0;
    end
    if (cmd.add) begin
      // round to nearest: add half the span before dividing
      rem_r <= NUM_W'(prod_r) + NUM_W'(span_r >> 1);
      cnt_r <= bsrt_pkg::DIV_FIRST;
    end
    if (cmd.div) begin
      if (rem_r >= div_sh) begin
        rem_r      <= rem_r - div_sh;
        q_r[cnt_r] <= 1'b1;
      end
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (cmd.commit) begin
      out_r.percent         <= shown_nxt;
      out_r.smoothed_mv     <= lv_r;
      out_r.ready_res       <= 1'b1;
      out_r.percent_changed <= (shown_nxt != shown_r);
    end
  end

  assign out_item = out_r;

endmodule

FILE: rtl/bsrt_ctrl.sv
// controller state machine sequencing one measurement through the datapath
`include "battery_soc_rate_limited_tracker_defines.svh"

module bsrt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bsrt_pkg::status_t st,
  output bsrt_pkg::cmd_t    cmd
);

  bsrt_pkg::state_t state_r;
  bsrt_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_free;

  // result register is free when empty or its beat leaves this cycle
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsrt_pkg::S_IDLE:   if (in_valid) state_nxt = bsrt_pkg::S_FILTER;
      bsrt_pkg::S_FILTER: state_nxt = bsrt_pkg::S_SEARCH;
      bsrt_pkg::S_SEARCH: begin
        if (st.seg_direct)     state_nxt = bsrt_pkg::S_UPDATE;
        else if (st.seg_found) state_nxt = bsrt_pkg::S_MULT;
      end
      bsrt_pkg::S_MULT:   state_nxt = bsrt_pkg::S_ADD;
      bsrt_pkg::S_ADD:    state_nxt = bsrt_pkg::S_DIV;
      bsrt_pkg::S_DIV:    if (st.div_last) state_nxt = bsrt_pkg::S_UPDATE;
      bsrt_pkg::S_UPDATE: if (out_free) state_nxt = bsrt_pkg::S_IDLE;
      default:            state_nxt = bsrt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      bsrt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      bsrt_pkg::S_FILTER: cmd.filter = 1'b1;
      bsrt_pkg::S_SEARCH: cmd.search = 1'b1;
      bsrt_pkg::S_MULT:   cmd.mult   = 1'b1;
      bsrt_pkg::S_ADD:    cmd.add    = 1'b1;
      bsrt_pkg::S_DIV:    cmd.div    = 1'b1;
      bsrt_pkg::S_UPDATE: cmd.commit = out_free;
      default: ;
    endcase
    out_valid_nxt = cmd.commit || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsrt_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `BSRT_ASSERT_NXT(a_load_starts_filter, cmd.load, state_r == bsrt_pkg::S_FILTER, "accepted beat did not start filtering")
  `BSRT_ASSERT_IMP(a_result_from_update, $rose(out_valid_r), $past(state_r) == bsrt_pkg::S_UPDATE, "result appeared outside update")
  `BSRT_ASSERT_NXT(a_div_runs_out, state_r == bsrt_pkg::S_DIV && !st.div_last, state_r == bsrt_pkg::S_DIV, "divider left early")
  `BSRT_ASSERT_IMP(a_no_overwrite, out_valid_r && !out_ready, !cmd.commit, "pending result overwritten")

endmodule

FILE: rtl/battery_soc_rate_limited_tracker.sv
// Battery state-of-charge tracker: each input beat (sample_mv, charging, now_ms) yields one
// result beat (percent, smoothed_mv, ready_res, percent_changed). The voltage is filtered by a
// 1/8 moving average, mapped through a 21-point rounded piecewise-linear curve and the shown
// percent moves by at most one step per configured interval, clamped below the cutoff voltage.
// Per beat the controller passes through idle, filter and the curve segment search, which
// checks one point per cycle (up to 21); an interpolated segment adds a multiply, a rounding add
// and a 7-step restoring divider before the update. A finished result sits in an output
// register, so the next beat is accepted while it waits; the following result is held back
// until that register is taken. Configuration writes are accepted every cycle.
module battery_soc_rate_limited_tracker (
  input  logic             clk,
  input  logic             rst_n,
  bsrt_in_if.sink          in_ch,
  bsrt_out_if.source       out_ch,
  bsrt_cfg_if.sink         cfg_ch
);

  bsrt_pkg::cmd_t    cmd;
  bsrt_pkg::status_t st;
  bsrt_pkg::cfg_t    cfg;

  assign cfg_ch.ready = 1'b1;

  bsrt_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid),
    .wr_beat (cfg_ch.data),
    .cfg     (cfg)
  );

  bsrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  bsrt_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .st       (st),
    .in_item  (in_ch.data),
    .cfg      (cfg),
    .out_item (out_ch.data)
  );

endmodule

FILE: verif/battery_soc_rate_limited_tracker_checker.sv
// scoreboard for the soc tracker: predicts every result beat and compares it field by field
module battery_soc_rate_limited_tracker_checker (
  input  logic       clk,
  input  logic       rst_n,
  bsrt_in_if         in_ch,
  bsrt_out_if        out_ch,
  bsrt_cfg_if        cfg_ch,
  output int         fail_count,
  output int         outstanding
);

  localparam int MV_W   = bsrt_pkg::MV_W;
  localparam int PCT_W  = bsrt_pkg::PCT_W;
  localparam int TIME_W = bsrt_pkg::TIME_W;
  localparam int KNEES  = 21;

  localparam int unsigned KNEE_MV [KNEES] = '{
    3450, 3610, 3690, 3710, 3730, 3750, 3770, 3790, 3800, 3820, 3840,
    3850, 3870, 3910, 3950, 3980, 4020, 4080, 4110, 4150, 4200
  };

  localparam int unsigned KNEE_PCT [KNEES] = '{
    0, 5, 10, 15, 20, 25, 30, 35, 40, 45, 50,
    55, 60, 65, 70, 75, 80, 85, 90, 95, 100
  };

  bsrt_pkg::cfg_t      limits;
  logic [MV_W-1:0]     filt_mv;
  logic [PCT_W-1:0]    soc_pct;
  logic                primed;
  logic [TIME_W-1:0]   stamp_ms;
  bsrt_pkg::out_item_t soc_due[$];

  // rounded linear interpolation between the two knees around mv
  function automatic logic [PCT_W-1:0] soc_from_mv(input logic [MV_W-1:0] mv);
    int unsigned span, rise, into;
    if (mv <= KNEE_MV[0]) return PCT_W'(KNEE_PCT[0]);
    for (int k = 1; k < KNEES; k++) begin
      if (mv <= KNEE_MV[k]) begin
        span = KNEE_MV[k] - KNEE_MV[k-1];
        rise = KNEE_PCT[k] - KNEE_PCT[k-1];
        into = mv - KNEE_MV[k-1];
        if (span == 0) return PCT_W'(KNEE_PCT[k]);
        return PCT_W'(KNEE_PCT[k-1] + (into * rise + span / 2) / span);
      end
    end
    return PCT_W'(100);
  endfunction

  task automatic track_reading(input bsrt_pkg::in_item_t m, output bsrt_pkg::out_item_t r);
    logic [PCT_W-1:0]  prior;
    logic [PCT_W-1:0]  goal;
    logic [TIME_W-1:0] gap_ms;
    prior = soc_pct;
    if (!primed) begin
      filt_mv  = m.sample_mv;
      soc_pct  = soc_from_mv(m.sample_mv);
      primed   = 1'b1;
      stamp_ms = m.now_ms;
    end else begin
      // a zero seed is replaced instead of filtered
      if (filt_mv == '0) begin
        filt_mv = m.sample_mv;
      end else begin
        filt_mv = MV_W'((32'(filt_mv) * 7 + 32'(m.sample_mv) + 4) / 8);
      end
      goal   = soc_from_mv(filt_mv);
      gap_ms = m.now_ms - stamp_ms;
      if (filt_mv <= limits.low_cutoff_mv) begin
        if (soc_pct > limits.low_clamp_percent) soc_pct = limits.low_clamp_percent;
        stamp_ms = m.now_ms;
      end else if (m.charging) begin
        if (goal > soc_pct && gap_ms >= limits.charge_step_ms) begin
          soc_pct  = soc_pct + 1'b1;
          stamp_ms = m.now_ms;
        end
      end else if (goal < soc_pct && gap_ms >= limits.discharge_step_ms) begin
        soc_pct  = soc_pct - 1'b1;
        stamp_ms = m.now_ms;
      end
    end
    r.percent         = soc_pct;
    r.smoothed_mv     = filt_mv;
    r.ready_res       = 1'b1;
    r.percent_changed = (soc_pct != prior);
  endtask

  task automatic match_field(input string field, input int unsigned want_v, got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", field, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    bsrt_pkg::out_item_t want;
    bsrt_pkg::out_item_t got;
    if (!rst_n) begin
      limits.charge_step_ms    = 32'd120000;
      limits.discharge_step_ms = 32'd300000;
      limits.low_cutoff_mv     = MV_W'(3500);
      limits.low_clamp_percent = PCT_W'(3);
      filt_mv    = '0;
      soc_pct    = '0;
      primed     = 1'b0;
      stamp_ms   = '0;
      fail_count = 0;
      soc_due.delete();
      outstanding <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.data.index)
          bsrt_pkg::CFG_CHARGE_STEP:
            limits.charge_step_ms = cfg_ch.data.value;
          bsrt_pkg::CFG_DISCHARGE_STEP:
            limits.discharge_step_ms = cfg_ch.data.value;
          bsrt_pkg::CFG_LOW_CUTOFF:
            limits.low_cutoff_mv = cfg_ch.data.value[MV_W-1:0];
          bsrt_pkg::CFG_LOW_CLAMP:
            limits.low_clamp_percent = cfg_ch.data.value[PCT_W-1:0];
          default: ;
        endcase
      end
      // results leave before the beat taken on the same edge is predicted
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (soc_due.size() == 0) begin
          $error("result beat with no measurement waiting for it");
          fail_count++;
        end else begin
          want = soc_due.pop_front();
          match_field("percent", want.percent, got.percent);
          match_field("smoothed_mv", want.smoothed_mv, got.smoothed_mv);
          match_field("ready_res", want.ready_res, got.ready_res);
          match_field("percent_changed", want.percent_changed, got.percent_changed);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        track_reading(in_ch.data, want);
        soc_due.push_back(want);
      end
      outstanding <= soc_due.size();
    end
  end

endmodule

FILE: verif/battery_soc_rate_limited_tracker_test.sv
// stimulus and verdict for the soc tracker, with the scoreboard instantiated beside the block
module battery_soc_rate_limited_tracker_test;

  localparam int MV_W         = bsrt_pkg::MV_W;
  localparam int TIME_W       = bsrt_pkg::TIME_W;
  localparam int CFG_IDX_W    = bsrt_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W   = bsrt_pkg::CFG_DATA_W;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 225;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = '1;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  int   cycle_cnt = 0;
  int   src_idle_pct = 16;
  int   sink_idle_pct = 74;

  int                base_mv;
  int                pick;
  logic              chg;
  logic [MV_W-1:0]   mv;
  logic [TIME_W-1:0] now_ms;
  logic [TIME_W-1:0] dt_ms;

  bsrt_in_if  meas_ch ();
  bsrt_out_if soc_ch ();
  bsrt_cfg_if reg_ch ();

  battery_soc_rate_limited_tracker uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (meas_ch),
    .out_ch (soc_ch),
    .cfg_ch (reg_ch)
  );

  battery_soc_rate_limited_tracker_checker scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (meas_ch),
    .out_ch      (soc_ch),
    .cfg_ch      (reg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    soc_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_meas(input logic [MV_W-1:0] m, input logic c,
                           input logic [TIME_W-1:0] t);
    while ($urandom_range(99) < src_idle_pct) begin
      meas_ch.valid <= 1'b0;
      @(posedge clk);
    end
    meas_ch.valid <= 1'b1;
    meas_ch.data  <= '{sample_mv: m, charging: c, now_ms: t};
    do @(posedge clk); while (!meas_ch.ready);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    reg_ch.valid <= 1'b1;
    reg_ch.data  <= '{index: idx, value: val};
    do @(posedge clk); while (!reg_ch.ready);
  endtask

  // every register, then a beat to an index past the last one that must be ignored
  task automatic load_limits(input logic [31:0] chg_step, dis_step, cutoff, clamp);
    put_reg(bsrt_pkg::CFG_CHARGE_STEP, chg_step);
    put_reg(bsrt_pkg::CFG_DISCHARGE_STEP, dis_step);
    put_reg(bsrt_pkg::CFG_LOW_CUTOFF, cutoff);
    put_reg(bsrt_pkg::CFG_LOW_CLAMP, clamp);
    put_reg(CFG_NO_REG, $urandom);
    reg_ch.valid <= 1'b0;
  endtask

  task automatic settle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n         <= 1'b0;
    meas_ch.valid <= 1'b0;
    meas_ch.data  <= '0;
    reg_ch.valid  <= 1'b0;
    reg_ch.data   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // seed with zero so the next reading replaces the average, then the field extremes
    send_meas('0, 1'b0, '0);
    send_meas('1, 1'b1, '1);
    send_meas(MV_W'(2500), 1'b0, '0);
    now_ms = 32'd120000;
    send_meas(MV_W'(5000), 1'b1, now_ms);
    // long discharge that drags the average under the cutoff and off the bottom of the curve
    for (int i = 0; i < 14; i++) begin
      now_ms = now_ms + 32'd300000;
      send_meas(MV_W'(2500), 1'b0, now_ms);
    end
    for (int i = 0; i < 4; i++) begin
      now_ms = now_ms + 32'd120000;
      send_meas(MV_W'(4200), 1'b1, now_ms);
    end
    now_ms = now_ms + 32'd119999;
    send_meas(MV_W'(4096), 1'b1, now_ms);
    send_meas(MV_W'(4201), 1'b0, now_ms);
    send_meas(MV_W'(3449), 1'b0, now_ms + 32'd300000);
    meas_ch.valid <= 1'b0;

    base_mv = 3800;
    chg     = 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        1: load_limits(32'd0, 32'd0, 32'd3700, 32'd100);
        2: load_limits('1, '1, 32'd0, 32'd0);
        // upper bits set to exercise masking of the narrow registers
        3: load_limits(32'd1, 32'd1, 32'hFFFF_E000 | 32'd3650, 32'hFFFF_FF80 | 32'd50);
        4: load_limits($urandom_range(200000), $urandom_range(500000),
                       $urandom_range(3400, 3900), $urandom_range(100));
        5: load_limits(32'd120000, 32'd300000, 32'd5000, 32'd3);
        default: ;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph * PHASE_ITEMS + n < 450) begin
          src_idle_pct  = 16;
          sink_idle_pct = 74;
        end else if (ph * PHASE_ITEMS + n < 900) begin
          src_idle_pct  = 74;
          sink_idle_pct = 16;
        end else begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
        // mostly a slow drift around a level, sometimes a wild reading
        if ($urandom_range(99) < 4) begin
          mv = MV_W'($urandom_range(8191));
        end else begin
          if ($urandom_range(39) == 0) base_mv = int'($urandom_range(3300, 4350));
          mv = MV_W'(base_mv + int'($urandom_range(80)) - 40);
        end
        if ($urandom_range(29) == 0) chg = ~chg;
        pick = int'($urandom_range(99));
        if (pick < 40) begin
          dt_ms = $urandom_range(1000);
        end else if (pick < 80) begin
          dt_ms = $urandom_range(400000);
        end else if (pick < 95) begin
          dt_ms = $urandom_range(2000000);
        end else begin
          dt_ms = $urandom;
        end
        now_ms = now_ms + dt_ms;
        send_meas(mv, chg, now_ms);
      end
      meas_ch.valid <= 1'b0;
    end

    settle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/bsrt_pkg.sv
rtl/bsrt_channels.sv
rtl/bsrt_cfg_regs.sv
rtl/bsrt_dp.sv
rtl/bsrt_ctrl.sv
rtl/battery_soc_rate_limited_tracker.sv
verif/battery_soc_rate_limited_tracker_checker.sv
verif/battery_soc_rate_limited_tracker_test.sv
